/* rtl/delt_pkg.sv */
// Shared constants, codes and types of the directory entry lock table.
package delt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int ACT_W   = 2;
  localparam int SPACE_W = 16;
  localparam int NAME_W  = 32;
  localparam int OWNER_W = 32;
  localparam int TRANS_W = 16;
  localparam int TAG_W   = 16;
  localparam int STAT_W  = 2;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_WAIT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NOWAIT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UNLOCK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd3;

  // Reply status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BLOCK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // Commands broadcast to the row of cells.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_APPEND,
    OP_DROP,
    OP_MOVE,
    OP_GRANT,
    OP_SETPEND
  } cell_op_e;

  typedef struct packed {
    logic               granted;
    logic [SPACE_W-1:0] space;
    logic               whole;
    logic [NAME_W-1:0]  name;
    logic               kind;
    logic [OWNER_W-1:0] owner;
    logic [TRANS_W-1:0] trans;
    logic [TAG_W-1:0]   tag;
    logic [IDX_W-1:0]   order;
  } slot_t;

  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] ord;
    logic [IDX_W-1:0] pos;
    slot_t            data;
  } cmd_t;

  typedef struct packed {
    logic [SPACE_W-1:0] space;
    logic               whole;
    logic [NAME_W-1:0]  name;
    logic [OWNER_W-1:0] owner;
    logic [TRANS_W-1:0] trans;
    logic               self_v;
    logic [IDX_W-1:0]   self_idx;
    logic [IDX_W-1:0]   rank;
    logic [IDX_W-1:0]   rd_idx;
  } qry_t;

  typedef struct packed {
    logic             free_f;
    logic [IDX_W-1:0] free_idx;
    logic             g_hit;
    logic             w_hit;
    logic             own;
    logic             all_f;
    logic [IDX_W-1:0] all_idx;
    logic             all_kind;
    logic [IDX_W-1:0] all_ord;
    logic             ex_f;
    logic [IDX_W-1:0] ex_idx;
    logic             ex_kind;
    logic [IDX_W-1:0] ex_ord;
    logic             rel_f;
    logic [IDX_W-1:0] rel_idx;
    logic [IDX_W-1:0] rel_ord;
    logic             rk_f;
    logic [IDX_W-1:0] rk_idx;
    slot_t            rk_slot;
    slot_t            rd_slot;
  } chain_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SPACE_W-1:0] space;
    logic               whole;
    logic [NAME_W-1:0]  name;
    logic               kind;
    logic [OWNER_W-1:0] owner;
    logic [TRANS_W-1:0] trans;
    logic [TAG_W-1:0]   tag;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [STAT_W-1:0] status;
  } rec_t;

endpackage

/* rtl/delt_if.sv */
// Request and reply channel interfaces of the lock table.
interface delt_req_if;
  logic                          valid;
  logic                          ready;
  logic [delt_pkg::ACT_W-1:0]    action;
  logic [delt_pkg::SPACE_W-1:0]  space_key;
  logic                          whole_dir;
  logic [delt_pkg::NAME_W-1:0]   name_key;
  logic                          lock_kind;
  logic [delt_pkg::OWNER_W-1:0]  owner_id;
  logic [delt_pkg::TRANS_W-1:0]  transport_id;
  logic [delt_pkg::TAG_W-1:0]    request_tag;

  modport source (output valid, action, space_key, whole_dir, name_key, lock_kind,
                  owner_id, transport_id, request_tag, input ready);
  modport sink (input valid, action, space_key, whole_dir, name_key, lock_kind,
                owner_id, transport_id, request_tag, output ready);
endinterface

interface delt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [delt_pkg::TAG_W-1:0]  reply_tag;
  logic [delt_pkg::STAT_W-1:0] status;
  logic                        last_reply;

  modport source (output valid, reply_tag, status, last_reply, input ready);
  modport sink (input valid, reply_tag, status, last_reply, output ready);
endinterface

/* rtl/delt_cell.sv */
// One lock slot: holds its entry, applies broadcast commands, extends the match chain.
module delt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [delt_pkg::IDX_W-1:0] idx_i,
  input  delt_pkg::cmd_t             cmd_i,
  input  delt_pkg::qry_t             qry_i,
  input  delt_pkg::chain_t           chain_i,
  output delt_pkg::chain_t           chain_o
);

  logic            used_q;
  logic            pend_q;
  delt_pkg::slot_t slot_q, slot_d;
  logic            me;
  logic            later;
  logic            sp_eq;
  logic            hit;
  logic            listed;
  logic            gsp;

  assign me    = (cmd_i.idx == idx_i);
  assign later = used_q && (slot_q.order > cmd_i.ord);

  // Occupancy and retry marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        delt_pkg::OP_APPEND: begin
          if (me) begin
            used_q <= 1'b1;
            pend_q <= 1'b0;
          end
        end
        delt_pkg::OP_DROP: begin
          if (me) begin
            used_q <= 1'b0;
            pend_q <= 1'b0;
          end
        end
        delt_pkg::OP_MOVE, delt_pkg::OP_GRANT: begin
          if (me) begin
            pend_q <= 1'b0;
          end
        end
        delt_pkg::OP_SETPEND: begin
          if (me) begin
            pend_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Entry contents and age rank; ranks behind a removed entry close the gap.
  always_comb begin
    slot_d = slot_q;
    case (cmd_i.op)
      delt_pkg::OP_APPEND: begin
        if (me) begin
          slot_d       = cmd_i.data;
          slot_d.order = cmd_i.pos;
        end
      end
      delt_pkg::OP_DROP: begin
        if (!me && later) begin
          slot_d.order = slot_q.order - delt_pkg::IDX_W'(1);
        end
      end
      delt_pkg::OP_MOVE, delt_pkg::OP_GRANT: begin
        if (me) begin
          slot_d.order = cmd_i.pos;
          if (cmd_i.op == delt_pkg::OP_GRANT) begin
            slot_d.granted = 1'b1;
          end
        end else if (later) begin
          slot_d.order = slot_q.order - delt_pkg::IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign sp_eq  = (slot_q.space == qry_i.space);
  assign hit    = used_q && sp_eq &&
                  (qry_i.whole || slot_q.whole || (slot_q.name == qry_i.name));
  assign listed = slot_q.granted ||
                  (!pend_q && !(qry_i.self_v && (qry_i.self_idx == idx_i)));
  assign gsp    = used_q && slot_q.granted && sp_eq;

  // Add this slot's contribution to the chain passed on to the next cell.
  always_comb begin
    chain_o = chain_i;
    if (!chain_i.free_f && !used_q) begin
      chain_o.free_f   = 1'b1;
      chain_o.free_idx = idx_i;
    end
    if (hit && slot_q.granted) begin
      chain_o.g_hit = 1'b1;
    end
    if (hit && !slot_q.granted && listed) begin
      chain_o.w_hit = 1'b1;
    end
    if (used_q && listed && sp_eq && (slot_q.owner == qry_i.owner) &&
        (slot_q.trans == qry_i.trans)) begin
      chain_o.own = 1'b1;
    end
    if (gsp && slot_q.whole) begin
      chain_o.all_f    = 1'b1;
      chain_o.all_idx  = idx_i;
      chain_o.all_kind = slot_q.kind;
      chain_o.all_ord  = slot_q.order;
    end else if (gsp && !qry_i.whole && (slot_q.name == qry_i.name)) begin
      chain_o.ex_f    = 1'b1;
      chain_o.ex_idx  = idx_i;
      chain_o.ex_kind = slot_q.kind;
      chain_o.ex_ord  = slot_q.order;
    end
    if (gsp && (slot_q.trans == qry_i.trans) && !chain_i.rel_f) begin
      chain_o.rel_f   = 1'b1;
      chain_o.rel_idx = idx_i;
      chain_o.rel_ord = slot_q.order;
    end
    if (used_q && (slot_q.order == qry_i.rank)) begin
      chain_o.rk_f    = 1'b1;
      chain_o.rk_idx  = idx_i;
      chain_o.rk_slot = slot_q;
    end
    if (qry_i.rd_idx == idx_i) begin
      chain_o.rd_slot = slot_q;
    end
  end

endmodule

/* rtl/delt_row.sv */
// Row of lock slots linked into one match chain.
module delt_row (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  delt_pkg::cmd_t   cmd_i,
  input  delt_pkg::qry_t   qry_i,
  output delt_pkg::chain_t chain_o
);

  delt_pkg::chain_t link [delt_pkg::ENTRIES+1];

  // The chain starts empty at slot zero.
  assign link[0] = '0;

  for (genvar g = 0; g < delt_pkg::ENTRIES; g++) begin : g_cell
    delt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (delt_pkg::IDX_W'(g)),
      .cmd_i   (cmd_i),
      .qry_i   (qry_i),
      .chain_i (link[g]),
      .chain_o (link[g+1])
    );
  end

  assign chain_o = link[delt_pkg::ENTRIES];

endmodule

/* rtl/directory_entry_lock_table.sv */
// A lock request is decided on evaluation and replied from the final state; a waiting lock
// is queued with no reply. Unlock and release sweep the age ranks (release sweeps twice);
// release drops the transport's waiters, one reply each, and frees its granted locks; both
// retry each listed waiter, reply per granted or refused retry, and end with the final reply.
// One request is worked on at a time; the next is accepted once its replies are queued.
// Reset empties every slot and clears the age count; slot contents need no clearing.
module directory_entry_lock_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  delt_req_if.sink    req_i,
  delt_rsp_if.source  rsp_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_SWEEP = 4'd2;
  localparam logic [3:0] S_GADDR = 4'd3;
  localparam logic [3:0] S_GEMIT = 4'd4;
  localparam logic [3:0] S_GDROP = 4'd5;
  localparam logic [3:0] S_RADDR = 4'd6;
  localparam logic [3:0] S_RLOAD = 4'd7;
  localparam logic [3:0] S_RCHK  = 4'd8;
  localparam logic [3:0] S_EADDR = 4'd9;
  localparam logic [3:0] S_EEMIT = 4'd10;
  localparam logic [3:0] S_FINAL = 4'd11;

  localparam int IW = delt_pkg::IDX_W;
  localparam int CW = delt_pkg::CNT_W;

  logic [3:0]                    state_q, state_d;
  delt_pkg::req_t                req_q, req_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [CW-1:0]                 r_q, r_d;
  logic [CW-1:0]                 tot_q, tot_d;
  logic [CW-1:0]                 n_q, n_d;
  logic [CW-1:0]                 i_q, i_d;
  logic [CW-1:0]                 nrec_q, nrec_d;
  logic                          gmode_q, gmode_d;
  logic [delt_pkg::STAT_W-1:0]   fin_q, fin_d;
  delt_pkg::slot_t               cur_q, cur_d;
  logic [IW-1:0]                 cur_idx_q, cur_idx_d;
  logic [CW-1:0]                 i_m1;
  logic [CW-1:0]                 cnt_m1;

  delt_pkg::cmd_t                cmd;
  delt_pkg::qry_t                qry;
  delt_pkg::chain_t              ch;
  logic                          must;

  // Waiter list and reply record memories.
  logic [IW-1:0]                 lst_mem [delt_pkg::ENTRIES];
  logic                          lst_we, lst_re;
  logic [IW-1:0]                 lst_wa, lst_ra, lst_wd, lst_rd_q;
  delt_pkg::rec_t                rec_mem [delt_pkg::ENTRIES];
  logic                          rec_we, rec_re;
  logic [IW-1:0]                 rec_wa, rec_ra;
  delt_pkg::rec_t                rec_wd, rec_rd_q;

  // Reply register.
  logic                          out_valid_q;
  logic [delt_pkg::TAG_W-1:0]    out_tag_q, out_tag_d;
  logic [delt_pkg::STAT_W-1:0]   out_st_q, out_st_d;
  logic                          out_last_q, out_last_d;
  logic                          out_load;
  logic                          out_free;

  delt_row u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .qry_i   (qry),
    .chain_o (ch)
  );

  assign out_free     = !out_valid_q || rsp_o.ready;
  assign req_i.ready  = (state_q == S_IDLE);
  assign i_m1         = i_q - CW'(1);
  assign cnt_m1       = cnt_q - CW'(1);
  assign must         = ch.g_hit || (ch.w_hit && !ch.own);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    cnt_d     = cnt_q;
    r_d       = r_q;
    tot_d     = tot_q;
    n_d       = n_q;
    i_d       = i_q;
    nrec_d    = nrec_q;
    gmode_d   = gmode_q;
    fin_d     = fin_q;
    cur_d     = cur_q;
    cur_idx_d = cur_idx_q;

    cmd              = '0;
    cmd.op           = delt_pkg::OP_NOP;
    cmd.data.granted = 1'b0;
    cmd.data.space   = req_q.space;
    cmd.data.whole   = req_q.whole;
    cmd.data.name    = req_q.whole ? '0 : req_q.name;
    cmd.data.kind    = req_q.kind;
    cmd.data.owner   = req_q.owner;
    cmd.data.trans   = req_q.trans;
    cmd.data.tag     = req_q.tag;

    qry.space    = req_q.space;
    qry.whole    = req_q.whole;
    qry.name     = req_q.whole ? '0 : req_q.name;
    qry.owner    = req_q.owner;
    qry.trans    = req_q.trans;
    qry.self_v   = 1'b0;
    qry.self_idx = cur_idx_q;
    qry.rank     = r_q[IW-1:0];
    qry.rd_idx   = lst_rd_q;

    lst_we = 1'b0;
    lst_wa = n_q[IW-1:0];
    lst_wd = ch.rk_idx;
    lst_re = 1'b0;
    lst_ra = i_q[IW-1:0];
    rec_we = 1'b0;
    rec_wa = nrec_q[IW-1:0];
    rec_wd.tag    = cur_q.tag;
    rec_wd.status = delt_pkg::ST_OK;
    rec_re = 1'b0;
    rec_ra = i_m1[IW-1:0];

    out_load   = 1'b0;
    out_tag_d  = req_q.tag;
    out_st_d   = fin_q;
    out_last_d = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d.action = req_i.action;
          req_d.space  = req_i.space_key;
          req_d.whole  = req_i.whole_dir;
          req_d.name   = req_i.name_key;
          req_d.kind   = req_i.lock_kind;
          req_d.owner  = req_i.owner_id;
          req_d.trans  = req_i.transport_id;
          req_d.tag    = req_i.request_tag;
          state_d      = S_EVAL;
        end
      end

      S_EVAL: begin
        nrec_d = '0;
        fin_d  = delt_pkg::ST_OK;
        case (req_q.action)
          delt_pkg::ACT_WAIT, delt_pkg::ACT_NOWAIT: begin
            cmd.idx = ch.free_idx;
            cmd.pos = cnt_q[IW-1:0];
            state_d = S_FINAL;
            if (!ch.free_f) begin
              fin_d = delt_pkg::ST_FULL;
            end else if (must) begin
              if (req_q.action == delt_pkg::ACT_NOWAIT) begin
                fin_d = delt_pkg::ST_BLOCK;
              end else begin
                cmd.op  = delt_pkg::OP_APPEND;
                state_d = S_IDLE;
              end
            end else if (req_q.kind) begin
              cmd.op           = delt_pkg::OP_APPEND;
              cmd.data.granted = 1'b1;
            end else begin
              fin_d = delt_pkg::ST_INVALID;
            end
          end
          delt_pkg::ACT_UNLOCK: begin
            state_d = S_FINAL;
            if (ch.ex_f ? (req_q.kind && ch.ex_kind)
                        : (ch.all_f && req_q.whole && req_q.kind && ch.all_kind)) begin
              cmd.op  = delt_pkg::OP_DROP;
              cmd.idx = ch.ex_f ? ch.ex_idx : ch.all_idx;
              cmd.ord = ch.ex_f ? ch.ex_ord : ch.all_ord;
              r_d     = '0;
              tot_d   = cnt_m1;
              n_d     = '0;
              gmode_d = 1'b0;
              state_d = S_SWEEP;
            end
          end
          default: begin
            r_d     = '0;
            tot_d   = cnt_q;
            n_d     = '0;
            gmode_d = 1'b1;
            state_d = S_SWEEP;
          end
        endcase
      end

      // Walk the ranks oldest first and list the waiters of interest.
      S_SWEEP: begin
        if (r_q == tot_q) begin
          if (gmode_q) begin
            i_d     = n_q;
            state_d = S_GADDR;
          end else begin
            i_d     = '0;
            state_d = S_RADDR;
          end
        end else begin
          if (ch.rk_f && !ch.rk_slot.granted && (ch.rk_slot.space == req_q.space) &&
              (!gmode_q || (ch.rk_slot.trans == req_q.trans))) begin
            lst_we = 1'b1;
            n_d    = n_q + CW'(1);
            if (!gmode_q) begin
              cmd.op  = delt_pkg::OP_SETPEND;
              cmd.idx = ch.rk_idx;
            end
          end
          r_d = r_q + CW'(1);
        end
      end

      // Dropped waiters of the transport, newest first.
      S_GADDR: begin
        if (i_q == '0) begin
          state_d = S_GDROP;
        end else begin
          lst_re  = 1'b1;
          lst_ra  = i_m1[IW-1:0];
          state_d = S_GEMIT;
        end
      end

      S_GEMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_tag_d  = ch.rd_slot.tag;
          out_st_d   = delt_pkg::ST_BLOCK;
          out_last_d = 1'b0;
          cmd.op     = delt_pkg::OP_DROP;
          cmd.idx    = lst_rd_q;
          cmd.ord    = ch.rd_slot.order;
          i_d        = i_m1;
          state_d    = S_GADDR;
        end
      end

      // Free the granted locks of the transport, one per cycle.
      S_GDROP: begin
        if (ch.rel_f) begin
          cmd.op  = delt_pkg::OP_DROP;
          cmd.idx = ch.rel_idx;
          cmd.ord = ch.rel_ord;
        end else begin
          r_d     = '0;
          tot_d   = cnt_q;
          n_d     = '0;
          gmode_d = 1'b0;
          state_d = S_SWEEP;
        end
      end

      // Retry each listed waiter in age order.
      S_RADDR: begin
        if (i_q == n_q) begin
          i_d     = nrec_q;
          state_d = S_EADDR;
        end else begin
          lst_re  = 1'b1;
          state_d = S_RLOAD;
        end
      end

      S_RLOAD: begin
        cur_d     = ch.rd_slot;
        cur_idx_d = lst_rd_q;
        state_d   = S_RCHK;
      end

      S_RCHK: begin
        qry.whole  = cur_q.whole;
        qry.name   = cur_q.name;
        qry.owner  = cur_q.owner;
        qry.trans  = cur_q.trans;
        qry.self_v = 1'b1;
        cmd.idx    = cur_idx_q;
        cmd.ord    = cur_q.order;
        cmd.pos    = cnt_m1[IW-1:0];
        if (must) begin
          cmd.op = delt_pkg::OP_MOVE;
        end else if (cur_q.kind) begin
          cmd.op = delt_pkg::OP_GRANT;
          rec_we = 1'b1;
          nrec_d = nrec_q + CW'(1);
        end else begin
          cmd.op        = delt_pkg::OP_DROP;
          rec_we        = 1'b1;
          rec_wd.status = delt_pkg::ST_INVALID;
          nrec_d        = nrec_q + CW'(1);
        end
        i_d     = i_q + CW'(1);
        state_d = S_RADDR;
      end

      // Retry outcomes, last retried first.
      S_EADDR: begin
        if (i_q == '0) begin
          state_d = S_FINAL;
        end else begin
          rec_re  = 1'b1;
          state_d = S_EEMIT;
        end
      end

      S_EEMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_tag_d  = rec_rd_q.tag;
          out_st_d   = rec_rd_q.status;
          out_last_d = 1'b0;
          i_d        = i_m1;
          state_d    = S_EADDR;
        end
      end

      S_FINAL: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Age count follows slots taken and freed.
    if (cmd.op == delt_pkg::OP_APPEND) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd.op == delt_pkg::OP_DROP) begin
      cnt_d = cnt_m1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    r_q       <= r_d;
    tot_q     <= tot_d;
    n_q       <= n_d;
    i_q       <= i_d;
    nrec_q    <= nrec_d;
    gmode_q   <= gmode_d;
    fin_q     <= fin_d;
    cur_q     <= cur_d;
    cur_idx_q <= cur_idx_d;
    if (out_load) begin
      out_tag_q  <= out_tag_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (lst_we) begin
      lst_mem[lst_wa] <= lst_wd;
    end
    if (lst_re) begin
      lst_rd_q <= lst_mem[lst_ra];
    end
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[rec_ra];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.reply_tag  = out_tag_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.last_reply = out_last_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the directory entry lock table.
`timescale 1ns / 100ps

module testbench;
  import delt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 200;

  typedef struct {
    bit [TAG_W-1:0]  tag;
    bit [STAT_W-1:0] status;
    bit              last;
  } reply_t;

  logic clk;
  logic rst_ni;

  delt_req_if req ();
  delt_rsp_if rsp ();

  directory_entry_lock_table dut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Shadow copy of the lock table.
  bit               lk_used   [ENTRIES];
  bit               lk_grant  [ENTRIES];
  bit [SPACE_W-1:0] lk_space  [ENTRIES];
  bit               lk_whole  [ENTRIES];
  bit [NAME_W-1:0]  lk_name   [ENTRIES];
  bit               lk_kind   [ENTRIES];
  bit [OWNER_W-1:0] lk_own_id [ENTRIES];
  bit [TRANS_W-1:0] lk_trans  [ENTRIES];
  bit [TAG_W-1:0]   lk_tag    [ENTRIES];
  int               lk_age    [ENTRIES];
  int               lk_count;

  reply_t pending_replies[$];
  reply_t regrant_log[$];

  int errors;
  int cycles = 0;
  int snd_idle;
  int rcv_idle;
  int hold_left;

  // Clock and cycle watchdog.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic void add_reply(ref reply_t q[$], input bit [TAG_W-1:0] tg,
                                    input bit [STAT_W-1:0] st, input bit last);
    reply_t r;
    r.tag = tg;
    r.status = st;
    r.last = last;
    q.push_back(r);
  endfunction

  // Remove a lock and close the gap in the age ranks.
  function automatic void unlink_lock(int s);
    for (int t = 0; t < ENTRIES; t++)
      if (lk_used[t] && t != s && lk_age[t] > lk_age[s])
        lk_age[t]--;
    lk_used[s] = 1'b0;
    lk_count--;
  endfunction

  function automatic void link_lock(int s);
    lk_age[s] = lk_count;
    lk_count++;
    lk_used[s] = 1'b1;
  endfunction

  function automatic bit overlaps(int t, bit [SPACE_W-1:0] sp, bit wh, bit [NAME_W-1:0] nm);
    if (lk_space[t] != sp)
      return 1'b0;
    return wh || lk_whole[t] || (lk_name[t] == nm);
  endfunction

  // A request must wait when it hits a granted lock, or hits a listed waiter while its
  // owner on the same transport holds nothing listed in the space.
  function automatic bit must_queue(bit [SPACE_W-1:0] sp, bit wh, bit [NAME_W-1:0] nm,
                                    bit [OWNER_W-1:0] ow, bit [TRANS_W-1:0] tr,
                                    bit skip[ENTRIES], int self_idx);
    bit wait_hit;
    bit owner_has;
    bit listed;
    wait_hit = 1'b0;
    owner_has = 1'b0;
    for (int t = 0; t < ENTRIES; t++) begin
      if (!lk_used[t])
        continue;
      listed = lk_grant[t] || (!skip[t] && t != self_idx);
      if (lk_grant[t] && overlaps(t, sp, wh, nm))
        return 1'b1;
      if (!lk_grant[t] && listed && overlaps(t, sp, wh, nm))
        wait_hit = 1'b1;
      if (listed && lk_space[t] == sp && lk_own_id[t] == ow && lk_trans[t] == tr)
        owner_has = 1'b1;
    end
    return wait_hit && !owner_has;
  endfunction

  function automatic int slot_at_age(int r);
    for (int t = 0; t < ENTRIES; t++)
      if (lk_used[t] && lk_age[t] == r)
        return t;
    return -1;
  endfunction

  // Retry every waiter of the space, oldest first.
  function automatic void retry_waiters(bit [SPACE_W-1:0] sp);
    int waiters[$];
    bit skip[ENTRIES];
    int total;
    int s;
    foreach (skip[i]) skip[i] = 1'b0;
    total = lk_count;
    for (int r = 0; r < total; r++) begin
      s = slot_at_age(r);
      if (s >= 0 && !lk_grant[s] && lk_space[s] == sp) begin
        waiters.push_back(s);
        skip[s] = 1'b1;
      end
    end
    foreach (waiters[i]) begin
      s = waiters[i];
      skip[s] = 1'b0;
      if (must_queue(sp, lk_whole[s], lk_name[s], lk_own_id[s], lk_trans[s], skip, s)) begin
        unlink_lock(s);
        link_lock(s);
      end else if (lk_kind[s]) begin
        unlink_lock(s);
        lk_grant[s] = 1'b1;
        link_lock(s);
        add_reply(regrant_log, lk_tag[s], ST_OK, 1'b0);
      end else begin
        add_reply(regrant_log, lk_tag[s], ST_INVALID, 1'b0);
        unlink_lock(s);
      end
    end
  endfunction

  // Update the shadow table for one accepted request and queue its replies.
  function automatic void predict_replies(bit [ACT_W-1:0] act, bit [SPACE_W-1:0] sp,
                                          bit wh, bit [NAME_W-1:0] nm_in, bit kd,
                                          bit [OWNER_W-1:0] ow, bit [TRANS_W-1:0] tr,
                                          bit [TAG_W-1:0] tg);
    bit none[ENTRIES];
    bit [NAME_W-1:0] nm;
    int fs;
    int ex;
    int al;
    int t;
    int s;
    int total;
    int gone[$];
    nm = wh ? '0 : nm_in;
    regrant_log.delete();
    foreach (none[i]) none[i] = 1'b0;
    if (act == ACT_WAIT || act == ACT_NOWAIT) begin
      fs = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (!lk_used[i] && fs < 0)
          fs = i;
      if (fs < 0) begin
        add_reply(pending_replies, tg, ST_FULL, 1'b1);
        return;
      end
      if (must_queue(sp, wh, nm, ow, tr, none, -1)) begin
        if (act == ACT_NOWAIT) begin
          add_reply(pending_replies, tg, ST_BLOCK, 1'b1);
          return;
        end
        lk_grant[fs] = 1'b0;
      end else if (kd) begin
        lk_grant[fs] = 1'b1;
      end else begin
        add_reply(pending_replies, tg, ST_INVALID, 1'b1);
        return;
      end
      lk_space[fs] = sp;
      lk_whole[fs] = wh;
      lk_name[fs] = nm;
      lk_kind[fs] = kd;
      lk_own_id[fs] = ow;
      lk_trans[fs] = tr;
      lk_tag[fs] = tg;
      link_lock(fs);
      if (lk_grant[fs])
        add_reply(pending_replies, tg, ST_OK, 1'b1);
      return;
    end
    if (act == ACT_UNLOCK) begin
      // Exact name match wins over a whole directory lock.
      al = -1;
      ex = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!lk_used[i] || !lk_grant[i] || lk_space[i] != sp)
          continue;
        if (lk_whole[i])
          al = i;
        else if (!wh && lk_name[i] == nm)
          ex = i;
      end
      t = (ex >= 0) ? ex : al;
      if (t >= 0 && lk_whole[t] == wh && kd && lk_kind[t]) begin
        unlink_lock(t);
        retry_waiters(sp);
      end
    end else begin
      // Release: drop the transport's waiters newest first, then its grants.
      total = lk_count;
      for (int r = 0; r < total; r++) begin
        s = slot_at_age(r);
        if (s >= 0 && !lk_grant[s] && lk_space[s] == sp && lk_trans[s] == tr)
          gone.push_back(s);
      end
      for (int i = gone.size() - 1; i >= 0; i--) begin
        add_reply(pending_replies, lk_tag[gone[i]], ST_BLOCK, 1'b0);
        unlink_lock(gone[i]);
      end
      for (int i = 0; i < ENTRIES; i++)
        if (lk_used[i] && lk_grant[i] && lk_space[i] == sp && lk_trans[i] == tr)
          unlink_lock(i);
      retry_waiters(sp);
    end
    for (int i = regrant_log.size() - 1; i >= 0; i--)
      pending_replies.push_back(regrant_log[i]);
    add_reply(pending_replies, tg, ST_OK, 1'b1);
  endfunction

  // Reply side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Compare each reply with the oldest prediction.
  always @(posedge clk) begin
    reply_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply tag %h status %0d last %0d", $time,
                 rsp.reply_tag, rsp.status, rsp.last_reply);
      end else begin
        e = pending_replies.pop_front();
        if (rsp.reply_tag !== e.tag || rsp.status !== e.status ||
            rsp.last_reply !== e.last) begin
          errors++;
          $display("%0t: reply mismatch: expected tag %h status %0d last %0d,",
                   $time, e.tag, e.status, e.last);
          $display("%0t:   got tag %h status %0d last %0d",
                   $time, rsp.reply_tag, rsp.status, rsp.last_reply);
        end
      end
    end
  end

  // Offer one request, idling first at the current rate; called at a falling edge.
  task automatic send_request(bit [ACT_W-1:0] act, bit [SPACE_W-1:0] sp, bit wh,
                              bit [NAME_W-1:0] nm, bit kd, bit [OWNER_W-1:0] ow,
                              bit [TRANS_W-1:0] tr, bit [TAG_W-1:0] tg);
    while ($urandom_range(99) < snd_idle) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.action = act;
    req.space_key = sp;
    req.whole_dir = wh;
    req.name_key = nm;
    req.lock_kind = kd;
    req.owner_id = ow;
    req.transport_id = tr;
    req.request_tag = tg;
    do @(posedge clk); while (!req.ready);
    predict_replies(act, sp, wh, nm, kd, ow, tr, tg);
    @(negedge clk);
  endtask

  // Wait until every predicted reply has arrived and the block has gone quiet.
  task automatic drain_replies();
    req.valid = 1'b0;
    while (pending_replies.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Random request drawn mostly from small key pools so that locks collide.
  task automatic send_random();
    int pick;
    bit wide;
    bit [ACT_W-1:0] act;
    pick = $urandom_range(99);
    wide = ($urandom_range(9) == 0);
    act = (pick < 35) ? ACT_WAIT : (pick < 55) ? ACT_NOWAIT :
          (pick < 85) ? ACT_UNLOCK : ACT_RELEASE;
    send_request(act,
                 wide ? SPACE_W'($urandom_range(65535)) : SPACE_W'($urandom_range(3)),
                 ($urandom_range(5) == 0),
                 wide ? NAME_W'($urandom) : NAME_W'($urandom_range(3)),
                 ($urandom_range(7) != 0),
                 wide ? OWNER_W'($urandom) : OWNER_W'($urandom_range(2)),
                 wide ? TRANS_W'($urandom_range(65535)) : TRANS_W'($urandom_range(2)),
                 TAG_W'($urandom_range(65535)));
  endtask

  // Grants, refusals, queued waiters, unlock matching and release.
  task automatic test_basic();
    send_request(ACT_WAIT,    16'h0000, 1'b0, 32'h0000_0000, 1'b1, 32'h0, 16'h0, 16'h0000);
    send_request(ACT_WAIT,    16'h0000, 1'b0, 32'h0000_0001, 1'b0, 32'h0, 16'h0, 16'h0001);
    send_request(ACT_NOWAIT,  16'h0000, 1'b0, 32'h0000_0000, 1'b1, 32'h1, 16'h1, 16'h0002);
    send_request(ACT_WAIT,    16'h0000, 1'b0, 32'h0000_0000, 1'b1, 32'h1, 16'h1, 16'h0003);
    send_request(ACT_WAIT,    16'h0000, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h2, 16'h2, 16'h0004);
    // Owner that already holds a lock in the space passes a waiting conflict.
    send_request(ACT_WAIT,    16'h0000, 1'b0, 32'h0000_0005, 1'b0, 32'h0, 16'h0, 16'h0005);
    send_request(ACT_WAIT,    16'h0000, 1'b0, 32'h0000_0006, 1'b0, 32'h3, 16'h3, 16'h0006);
    send_request(ACT_UNLOCK,  16'h0000, 1'b0, 32'h0000_0077, 1'b1, 32'h0, 16'h0, 16'h0007);
    send_request(ACT_UNLOCK,  16'h0000, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'h0, 16'h0008);
    send_request(ACT_UNLOCK,  16'h0000, 1'b0, 32'h0000_0000, 1'b1, 32'h0, 16'h0, 16'h0009);
    send_request(ACT_UNLOCK,  16'h0000, 1'b1, 32'h0000_0000, 1'b1, 32'h1, 16'h1, 16'h000A);
    send_request(ACT_WAIT,    16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,
                 16'hFFFF);
    send_request(ACT_WAIT,    16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hAAAA_5555, 16'h5555,
                 16'h5555);
    send_request(ACT_WAIT,    16'hFFFF, 1'b0, 32'h0000_0000, 1'b0, 32'h5555_AAAA, 16'hAAAA,
                 16'hAAAA);
    send_request(ACT_RELEASE, 16'hFFFF, 1'b0, 32'h0, 1'b0, 32'h0, 16'h5555, 16'h000B);
    send_request(ACT_RELEASE, 16'hFFFF, 1'b0, 32'h0, 1'b0, 32'h0, 16'hFFFF, 16'h000C);
    send_request(ACT_RELEASE, 16'h0000, 1'b0, 32'h0, 1'b0, 32'h0, 16'h0003, 16'h000D);
    send_request(ACT_RELEASE, 16'h0000, 1'b0, 32'h0, 1'b0, 32'h0, 16'h0000, 16'h000E);
    send_request(ACT_RELEASE, 16'h0000, 1'b0, 32'h0, 1'b0, 32'h0, 16'h0002, 16'h000F);
    drain_replies();
  endtask

  // Fill every slot, hit the full table with both kinds, then free it all.
  task automatic test_full_table();
    for (int i = 0; i < ENTRIES; i++)
      send_request(ACT_WAIT, 16'h0100, 1'b0, NAME_W'(i), 1'b1, 32'h9, 16'h9, TAG_W'(16'h100 + i));
    send_request(ACT_WAIT,   16'h0100, 1'b0, 32'h1234, 1'b1, 32'h9, 16'h9, 16'h0200);
    send_request(ACT_NOWAIT, 16'h0100, 1'b0, 32'h0000, 1'b0, 32'h8, 16'h8, 16'h0201);
    send_request(ACT_RELEASE, 16'h0100, 1'b0, 32'h0, 1'b0, 32'h0, 16'h9, 16'h0202);
    drain_replies();
  endtask

  task automatic test_random(int sender_pct, int receiver_pct, int count);
    snd_idle = sender_pct;
    rcv_idle = receiver_pct;
    repeat (count) send_random();
    drain_replies();
  endtask

  // Receiver holds off while requests keep coming, so the block stalls its input.
  task automatic test_backpressure();
    snd_idle = 0;
    rcv_idle = 0;
    hold_left = 400;
    repeat (30) send_random();
    drain_replies();
  endtask

  initial begin
    errors = 0;
    hold_left = 0;
    snd_idle = 0;
    rcv_idle = 0;
    lk_count = 0;
    foreach (lk_used[i]) lk_used[i] = 1'b0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.action = ACT_WAIT;
    req.space_key = '0;
    req.whole_dir = 1'b0;
    req.name_key = '0;
    req.lock_kind = 1'b0;
    req.owner_id = '0;
    req.transport_id = '0;
    req.request_tag = '0;
    rsp.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_basic();
    test_full_table();
    test_random(24, 72, 90);
    test_random(72, 24, 90);
    test_random(0, 0, 90);
    test_backpressure();

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/delt_pkg.sv
rtl/delt_if.sv
rtl/delt_cell.sv
rtl/delt_row.sv
rtl/directory_entry_lock_table.sv
tb/testbench.sv
